FILE: rtl/core/midpoint_ellipse_walker_defines.svh
// Assertion macros shared by the ellipse walker RTL.
`ifndef MIDPOINT_ELLIPSE_WALKER_DEFINES_SVH
`define MIDPOINT_ELLIPSE_WALKER_DEFINES_SVH

// Same-cycle implication, clocked on clk and idle during reset.
`define MEW_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on clk and idle during reset.
`define MEW_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/mew_pkg.sv
// Shared constants, width helpers and types for the ellipse walker.
package mew_pkg;

    localparam int COORD_BITS_DEF = 10;
    localparam int CFG_IDX_W      = 2;

    localparam logic [CFG_IDX_W-1:0] REG_CENTER_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SEMI_A   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SEMI_B   = 2'd3;

    localparam logic [1:0] PH_DONE    = 2'd0;
    localparam logic [1:0] PH_REGION1 = 2'd1;
    localparam logic [1:0] PH_REGION2 = 2'd2;

    typedef struct packed {
        logic point_valid;
        logic last_point;
    } step_flags_t;

    function automatic int axis_w(input int cb);
        return cb - 1;
    endfunction

    function automatic int sq_w(input int cb);
        return 2 * (cb - 1);
    endfunction

    function automatic int off_w(input int cb);
        return cb + 1;
    endfunction

    function automatic int slope_w(input int cb);
        return 3 * (cb - 1) + 4;
    endfunction

    function automatic int dec_w(input int cb);
        return 4 * (cb - 1) + 6;
    endfunction

    function automatic int out_w(input int cb);
        return cb + 2;
    endfunction

    // Multiplier port A carries semi-axes, squares and the running products b^2*(2x+1) and a^2*|y-1|
    function automatic int mul_a_w(input int cb);
        return 2 * (cb - 1) + cb + 2;
    endfunction

    // Multiplier port B carries semi-axes, 2x+1, |y-1| and b^2
    function automatic int mul_b_w(input int cb);
        return (2 * (cb - 1) > cb + 2) ? 2 * (cb - 1) : cb + 2;
    endfunction

endpackage

FILE: rtl/core/mew_mul.sv
// Shared multiplier with a registered product.
module mew_mul
    import mew_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  logic                                                 clk,
    input  logic [mul_a_w(COORD_BITS)-1:0]                       op_a,
    input  logic [mul_b_w(COORD_BITS)-1:0]                       op_b,
    output logic [mul_a_w(COORD_BITS)+mul_b_w(COORD_BITS)-1:0]   prod
);

    localparam int P_W = mul_a_w(COORD_BITS) + mul_b_w(COORD_BITS);

    logic [P_W-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= P_W'(op_a) * P_W'(op_b);
    end

    assign prod = prod_reg;

endmodule

FILE: rtl/core/mew_step.sv
// One midpoint step: next walk state and the four mirrored coordinates.
module mew_step
    import mew_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  logic [1:0]                               phase,
    input  logic signed [off_w(COORD_BITS)-1:0]      off_x,
    input  logic signed [off_w(COORD_BITS)-1:0]      off_y,
    input  logic signed [slope_w(COORD_BITS)-1:0]    slope_dx,
    input  logic signed [slope_w(COORD_BITS)-1:0]    slope_dy,
    input  logic signed [dec_w(COORD_BITS)-1:0]      decision,
    input  logic [sq_w(COORD_BITS)-1:0]              a_sq,
    input  logic [sq_w(COORD_BITS)-1:0]              b_sq,
    input  logic [COORD_BITS-1:0]                    center_x,
    input  logic [COORD_BITS-1:0]                    center_y,
    output logic [1:0]                               phase_next,
    output logic signed [off_w(COORD_BITS)-1:0]      off_x_next,
    output logic signed [off_w(COORD_BITS)-1:0]      off_y_next,
    output logic signed [slope_w(COORD_BITS)-1:0]    slope_dx_next,
    output logic signed [slope_w(COORD_BITS)-1:0]    slope_dy_next,
    output logic signed [dec_w(COORD_BITS)-1:0]      decision_next,
    output step_flags_t                              flags,
    output logic signed [out_w(COORD_BITS)-1:0]      right_x,
    output logic signed [out_w(COORD_BITS)-1:0]      left_x,
    output logic signed [out_w(COORD_BITS)-1:0]      upper_y,
    output logic signed [out_w(COORD_BITS)-1:0]      lower_y
);

    localparam int OFF_W = off_w(COORD_BITS);
    localparam int SL_W  = slope_w(COORD_BITS);
    localparam int DEC_W = dec_w(COORD_BITS);
    localparam int OUT_W = out_w(COORD_BITS);

    logic signed [SL_W-1:0]  two_b2;
    logic signed [SL_W-1:0]  two_a2;
    logic signed [SL_W-1:0]  dx_inc;
    logic signed [SL_W-1:0]  dy_dec;
    logic signed [DEC_W-1:0] a2_d;
    logic signed [DEC_W-1:0] b2_d;
    logic signed [OFF_W-1:0] x_inc;
    logic signed [OFF_W-1:0] y_dec;
    logic signed [OUT_W-1:0] cx_s;
    logic signed [OUT_W-1:0] cy_s;
    logic signed [OUT_W-1:0] x_s;
    logic signed [OUT_W-1:0] y_s;
    logic                    live;
    logic                    more;

    assign two_b2 = $signed(SL_W'({b_sq, 1'b0}));
    assign two_a2 = $signed(SL_W'({a_sq, 1'b0}));
    assign dx_inc = slope_dx + two_b2;
    assign dy_dec = slope_dy - two_a2;
    assign a2_d   = $signed(DEC_W'(a_sq));
    assign b2_d   = $signed(DEC_W'(b_sq));
    assign x_inc  = off_x + OFF_W'(1);
    assign y_dec  = off_y - OFF_W'(1);

    assign cx_s = $signed({2'b00, center_x});
    assign cy_s = $signed({2'b00, center_y});
    assign x_s  = $signed({off_x[OFF_W-1], off_x});
    assign y_s  = $signed({off_y[OFF_W-1], off_y});

    always_comb
    begin
        phase_next    = PH_DONE;
        off_x_next    = off_x;
        off_y_next    = off_y;
        slope_dx_next = slope_dx;
        slope_dy_next = slope_dy;
        decision_next = decision;
        live          = 1'b0;
        more          = 1'b0;
        case (phase)
            PH_REGION1:
            begin
                live          = 1'b1;
                phase_next    = PH_REGION1;
                slope_dx_next = dx_inc;
                off_x_next    = x_inc;
                if (decision[DEC_W-1])
                begin
                    decision_next = decision + DEC_W'(dx_inc) + b2_d;
                end
                else
                begin
                    off_y_next    = y_dec;
                    slope_dy_next = dy_dec;
                    decision_next = decision + DEC_W'(dx_inc) - DEC_W'(dy_dec) + b2_d;
                end
                more = (dx_inc < slope_dy_next) || !off_y_next[OFF_W-1];
            end
            PH_REGION2:
            begin
                // walk ends once y has gone below the axis
                if (!off_y[OFF_W-1])
                begin
                    live          = 1'b1;
                    phase_next    = PH_REGION2;
                    slope_dy_next = dy_dec;
                    off_y_next    = y_dec;
                    if (decision > DEC_W'(0))
                    begin
                        decision_next = decision + a2_d - DEC_W'(dy_dec);
                    end
                    else
                    begin
                        off_x_next    = x_inc;
                        slope_dx_next = dx_inc;
                        decision_next = decision + DEC_W'(dx_inc) - DEC_W'(dy_dec) + a2_d;
                    end
                    more = !y_dec[OFF_W-1];
                end
            end
            default:
            begin
                phase_next = PH_DONE;
            end
        endcase
    end

    assign flags.point_valid = live;
    assign flags.last_point  = live && !more;

    assign right_x = live ? cx_s + x_s : '0;
    assign left_x  = live ? cx_s - x_s : '0;
    assign upper_y = live ? cy_s + y_s : '0;
    assign lower_y = live ? cy_s - y_s : '0;

endmodule

FILE: rtl/core/midpoint_ellipse_walker.sv
// Top level of the midpoint ellipse walker: sequencer, walk state and output register.
// Walks one quadrant of the midpoint ellipse from the top point (0, b) and returns each point
// mirrored into all four quadrants. Load centre and semi-axes through the write port, then
// send a restart transaction (result carries no point) followed by advance transactions, one
// point each; last_point marks the final point and further advances return point_valid=0.
// A plain advance steps straight from idle, so points stream at one per clock while the
// output is taken and no region switch is due. A restart holds the input through setup, a
// region one to two switch through its entry sequence; both are paced by the single shared
// multiplier, which forms the squares and starting decision one registered product per cycle.
module midpoint_ellipse_walker
    import mew_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write_en,
    input  logic [CFG_IDX_W-1:0]                cfg_index,
    input  logic [COORD_BITS-1:0]               cfg_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                restart,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic                                point_valid,
    output logic signed [out_w(COORD_BITS)-1:0] right_x,
    output logic signed [out_w(COORD_BITS)-1:0] left_x,
    output logic signed [out_w(COORD_BITS)-1:0] upper_y,
    output logic signed [out_w(COORD_BITS)-1:0] lower_y,
    output logic                                last_point
);

`include "midpoint_ellipse_walker_defines.svh"

    localparam int AX_W  = axis_w(COORD_BITS);
    localparam int SQ_W  = sq_w(COORD_BITS);
    localparam int OFF_W = off_w(COORD_BITS);
    localparam int SL_W  = slope_w(COORD_BITS);
    localparam int DEC_W = dec_w(COORD_BITS);
    localparam int NUM_W = dec_w(COORD_BITS) + 2;
    localparam int OUT_W = out_w(COORD_BITS);
    localparam int MA_W  = mul_a_w(COORD_BITS);
    localparam int MB_W  = mul_b_w(COORD_BITS);
    localparam int P_W   = mul_a_w(COORD_BITS) + mul_b_w(COORD_BITS);

    // setup sequence after a restart
    localparam logic [2:0] INI_A_SQ  = 3'd0;
    localparam logic [2:0] INI_B_SQ  = 3'd1;
    localparam logic [2:0] INI_A2B   = 3'd2;
    localparam logic [2:0] INI_SUM   = 3'd3;
    localparam logic [2:0] INI_LOAD  = 3'd4;
    // region two entry sequence
    localparam logic [2:0] SW_B2TX   = 3'd0;
    localparam logic [2:0] SW_PTX    = 3'd1;
    localparam logic [2:0] SW_A2TY   = 3'd2;
    localparam logic [2:0] SW_QTY    = 3'd3;
    localparam logic [2:0] SW_A2B2   = 3'd4;
    localparam logic [2:0] SW_SUB    = 3'd5;
    localparam logic [2:0] SW_LOAD   = 3'd6;

    typedef enum logic [1:0] {
        S_IDLE,
        S_INIT,
        S_SWITCH,
        S_POINT
    } state_t;

    // configuration
    logic [COORD_BITS-1:0] center_x_reg;
    logic [COORD_BITS-1:0] center_y_reg;
    logic [AX_W-1:0]       semi_a_reg;
    logic [AX_W-1:0]       semi_b_reg;

    // sequencer and walk state
    state_t                  state_reg,    state_next;
    logic [2:0]              cnt_reg,      cnt_next;
    logic [1:0]              phase_reg,    phase_next;
    logic signed [OFF_W-1:0] off_x_reg,    off_x_next;
    logic signed [OFF_W-1:0] off_y_reg,    off_y_next;
    logic signed [SL_W-1:0]  slope_dx_reg, slope_dx_next;
    logic signed [SL_W-1:0]  slope_dy_reg, slope_dy_next;
    logic signed [DEC_W-1:0] decision_reg, decision_next;
    logic signed [NUM_W-1:0] acc_reg,      acc_next;
    logic [SQ_W-1:0]         a_sq_reg,     a_sq_next;
    logic [SQ_W-1:0]         b_sq_reg,     b_sq_next;

    // output register
    logic                    out_valid_reg,   out_valid_next;
    logic                    point_valid_reg, point_valid_next;
    logic                    last_point_reg,  last_point_next;
    logic signed [OUT_W-1:0] right_x_reg,     right_x_next;
    logic signed [OUT_W-1:0] left_x_reg,      left_x_next;
    logic signed [OUT_W-1:0] upper_y_reg,     upper_y_next;
    logic signed [OUT_W-1:0] lower_y_reg,     lower_y_next;

    logic                    in_accept;
    logic                    out_free;
    logic                    take_step;
    logic                    load_blank;
    logic [MA_W-1:0]         op_a;
    logic [MB_W-1:0]         op_b;
    logic [P_W-1:0]          prod;
    logic [OFF_W:0]          tx;
    logic signed [OFF_W-1:0] ty;
    logic [OFF_W-1:0]        ty_mag;
    logic signed [NUM_W-1:0] acc_round;
    logic signed [DEC_W-1:0] quarter_val;

    logic [1:0]              step_phase;
    logic signed [OFF_W-1:0] step_x;
    logic signed [OFF_W-1:0] step_y;
    logic signed [SL_W-1:0]  step_dx;
    logic signed [SL_W-1:0]  step_dy;
    logic signed [DEC_W-1:0] step_dec;
    step_flags_t             step_flags;
    logic signed [OUT_W-1:0] step_right_x;
    logic signed [OUT_W-1:0] step_left_x;
    logic signed [OUT_W-1:0] step_upper_y;
    logic signed [OUT_W-1:0] step_lower_y;

    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != S_IDLE) || (out_valid_reg && out_stall);
    assign in_accept = in_valid && !in_stall;

    assign tx     = {off_x_reg, 1'b1};
    assign ty     = off_y_reg - OFF_W'(1);
    assign ty_mag = ty[OFF_W-1] ? -ty : ty;

    // add three before the shift so negative quarters truncate toward zero
    assign acc_round   = acc_reg + $signed(NUM_W'({acc_reg[NUM_W-1], acc_reg[NUM_W-1]}));
    assign quarter_val = $signed(acc_round[NUM_W-1:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_x_reg <= '0;
            center_y_reg <= '0;
            semi_a_reg   <= '0;
            semi_b_reg   <= '0;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                REG_CENTER_X: center_x_reg <= cfg_data;
                REG_CENTER_Y: center_y_reg <= cfg_data;
                REG_SEMI_A:   semi_a_reg   <= cfg_data[AX_W-1:0];
                REG_SEMI_B:   semi_b_reg   <= cfg_data[AX_W-1:0];
                default:      ;
            endcase
        end
    end

    mew_mul #(
        .COORD_BITS (COORD_BITS)
    ) u_mul (
        .clk  (clk),
        .op_a (op_a),
        .op_b (op_b),
        .prod (prod)
    );

    mew_step #(
        .COORD_BITS (COORD_BITS)
    ) u_step (
        .phase         (phase_reg),
        .off_x         (off_x_reg),
        .off_y         (off_y_reg),
        .slope_dx      (slope_dx_reg),
        .slope_dy      (slope_dy_reg),
        .decision      (decision_reg),
        .a_sq          (a_sq_reg),
        .b_sq          (b_sq_reg),
        .center_x      (center_x_reg),
        .center_y      (center_y_reg),
        .phase_next    (step_phase),
        .off_x_next    (step_x),
        .off_y_next    (step_y),
        .slope_dx_next (step_dx),
        .slope_dy_next (step_dy),
        .decision_next (step_dec),
        .flags         (step_flags),
        .right_x       (step_right_x),
        .left_x        (step_left_x),
        .upper_y       (step_upper_y),
        .lower_y       (step_lower_y)
    );

    // operand selection for the shared multiplier
    always_comb
    begin
        op_a = '0;
        op_b = '0;
        case (state_reg)
            S_INIT:
            begin
                case (cnt_reg)
                    INI_A_SQ:
                    begin
                        op_a = MA_W'(semi_a_reg);
                        op_b = MB_W'(semi_a_reg);
                    end
                    INI_B_SQ:
                    begin
                        op_a = MA_W'(semi_b_reg);
                        op_b = MB_W'(semi_b_reg);
                    end
                    INI_A2B:
                    begin
                        op_a = MA_W'(a_sq_reg);
                        op_b = MB_W'(semi_b_reg);
                    end
                    default: ;
                endcase
            end
            S_SWITCH:
            begin
                case (cnt_reg)
                    SW_B2TX:
                    begin
                        op_a = MA_W'(b_sq_reg);
                        op_b = MB_W'(tx);
                    end
                    SW_PTX:
                    begin
                        op_a = MA_W'(prod);
                        op_b = MB_W'(tx);
                    end
                    SW_A2TY:
                    begin
                        op_a = MA_W'(a_sq_reg);
                        op_b = MB_W'(ty_mag);
                    end
                    SW_QTY:
                    begin
                        op_a = MA_W'(prod);
                        op_b = MB_W'(ty_mag);
                    end
                    SW_A2B2:
                    begin
                        op_a = MA_W'(a_sq_reg);
                        op_b = MB_W'(b_sq_reg);
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
    end

    always_comb
    begin
        state_next       = state_reg;
        cnt_next         = cnt_reg;
        phase_next       = phase_reg;
        off_x_next       = off_x_reg;
        off_y_next       = off_y_reg;
        slope_dx_next    = slope_dx_reg;
        slope_dy_next    = slope_dy_reg;
        decision_next    = decision_reg;
        acc_next         = acc_reg;
        a_sq_next        = a_sq_reg;
        b_sq_next        = b_sq_reg;
        out_valid_next   = out_valid_reg && out_stall;
        point_valid_next = point_valid_reg;
        last_point_next  = last_point_reg;
        right_x_next     = right_x_reg;
        left_x_next      = left_x_reg;
        upper_y_next     = upper_y_reg;
        lower_y_next     = lower_y_reg;
        take_step        = 1'b0;
        load_blank       = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    if (restart)
                    begin
                        state_next = S_INIT;
                        cnt_next   = INI_A_SQ;
                    end
                    else if (phase_reg == PH_REGION1 && !(slope_dx_reg < slope_dy_reg))
                    begin
                        state_next = S_SWITCH;
                        cnt_next   = SW_B2TX;
                    end
                    else
                    begin
                        take_step = 1'b1;
                    end
                end
            end
            S_INIT:
            begin
                cnt_next = cnt_reg + 3'd1;
                case (cnt_reg)
                    INI_B_SQ:
                    begin
                        a_sq_next = SQ_W'(prod);
                    end
                    INI_A2B:
                    begin
                        b_sq_next = SQ_W'(prod);
                    end
                    INI_SUM:
                    begin
                        // numerator 4b^2 - 4a^2*b + a^2
                        acc_next = $signed(NUM_W'({b_sq_reg, 2'b00}))
                                 - $signed(NUM_W'({prod, 2'b00}))
                                 + $signed(NUM_W'(a_sq_reg));
                        slope_dy_next = $signed(SL_W'({prod, 1'b0}));
                        slope_dx_next = '0;
                        off_x_next    = '0;
                        off_y_next    = $signed(OFF_W'(semi_b_reg));
                    end
                    INI_LOAD:
                    begin
                        cnt_next = cnt_reg;
                        if (out_free)
                        begin
                            decision_next = quarter_val;
                            phase_next    = PH_REGION1;
                            load_blank    = 1'b1;
                            state_next    = S_IDLE;
                        end
                    end
                    default: ;
                endcase
            end
            S_SWITCH:
            begin
                cnt_next = cnt_reg + 3'd1;
                case (cnt_reg)
                    SW_A2TY:
                    begin
                        acc_next = $signed(NUM_W'(prod));
                    end
                    SW_A2B2:
                    begin
                        acc_next = acc_reg + $signed(NUM_W'({prod, 2'b00}));
                    end
                    SW_SUB:
                    begin
                        acc_next = acc_reg - $signed(NUM_W'({prod, 2'b00}));
                    end
                    SW_LOAD:
                    begin
                        decision_next = quarter_val;
                        phase_next    = PH_REGION2;
                        state_next    = S_POINT;
                    end
                    default: ;
                endcase
            end
            S_POINT:
            begin
                if (out_free)
                begin
                    take_step  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (take_step)
        begin
            phase_next       = step_phase;
            off_x_next       = step_x;
            off_y_next       = step_y;
            slope_dx_next    = step_dx;
            slope_dy_next    = step_dy;
            decision_next    = step_dec;
            out_valid_next   = 1'b1;
            point_valid_next = step_flags.point_valid;
            last_point_next  = step_flags.last_point;
            right_x_next     = step_right_x;
            left_x_next      = step_left_x;
            upper_y_next     = step_upper_y;
            lower_y_next     = step_lower_y;
        end

        if (load_blank)
        begin
            out_valid_next   = 1'b1;
            point_valid_next = 1'b0;
            last_point_next  = 1'b0;
            right_x_next     = '0;
            left_x_next      = '0;
            upper_y_next     = '0;
            lower_y_next     = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            cnt_reg         <= '0;
            phase_reg       <= PH_DONE;
            off_x_reg       <= '0;
            off_y_reg       <= '0;
            slope_dx_reg    <= '0;
            slope_dy_reg    <= '0;
            decision_reg    <= '0;
            acc_reg         <= '0;
            a_sq_reg        <= '0;
            b_sq_reg        <= '0;
            out_valid_reg   <= 1'b0;
            point_valid_reg <= 1'b0;
            last_point_reg  <= 1'b0;
            right_x_reg     <= '0;
            left_x_reg      <= '0;
            upper_y_reg     <= '0;
            lower_y_reg     <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            cnt_reg         <= cnt_next;
            phase_reg       <= phase_next;
            off_x_reg       <= off_x_next;
            off_y_reg       <= off_y_next;
            slope_dx_reg    <= slope_dx_next;
            slope_dy_reg    <= slope_dy_next;
            decision_reg    <= decision_next;
            acc_reg         <= acc_next;
            a_sq_reg        <= a_sq_next;
            b_sq_reg        <= b_sq_next;
            out_valid_reg   <= out_valid_next;
            point_valid_reg <= point_valid_next;
            last_point_reg  <= last_point_next;
            right_x_reg     <= right_x_next;
            left_x_reg      <= left_x_next;
            upper_y_reg     <= upper_y_next;
            lower_y_reg     <= lower_y_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign point_valid = point_valid_reg;
    assign last_point  = last_point_reg;
    assign right_x     = right_x_reg;
    assign left_x      = left_x_reg;
    assign upper_y     = upper_y_reg;
    assign lower_y     = lower_y_reg;

    `MEW_ASSERT_NEXT(a_restart_setup, in_accept && restart, state_reg == S_INIT, "restart transaction did not enter setup")
    `MEW_ASSERT_NOW(a_last_has_point, out_valid_reg && last_point_reg, point_valid_reg, "last point flagged on a result without a point")
    `MEW_ASSERT_NOW(a_walk_alive, out_valid_reg && point_valid_reg && !last_point_reg, phase_reg != PH_DONE, "walk finished although more points were promised")
    `MEW_ASSERT_NEXT(a_single_cycle_step, in_accept && !restart && phase_reg == PH_REGION1 && slope_dx_reg < slope_dy_reg, out_valid_reg && point_valid_reg, "region one advance did not deliver a point in one cycle")

endmodule
